[rtl/core/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants of the cosine similarity core
// Field widths, the pair limit and the record passed from front to back end.
// ----------------------------------------------------------------------------
package csa_pkg;

	localparam int IN_W  = 24;
	localparam int SUM_W = 64;
	localparam int PRD_W = 2 * IN_W;
	localparam int CNT_W = 13;
	localparam int SIM_W = 16;

	localparam logic [CNT_W-1:0] MAX_PAIRS = 13'd4096;
	localparam logic [SIM_W-1:0] SIM_ONE   = 16'd32768;

	// one finished vector pair: its three sums and its pair count
	typedef struct packed {
		logic [SUM_W-1:0] cross_sum;
		logic [SUM_W-1:0] first_sq;
		logic [SUM_W-1:0] second_sq;
		logic [CNT_W-1:0] count;
	} sums_t;

endpackage

[rtl/core/csa_fifo.sv]
// ----------------------------------------------------------------------------
// csa_fifo: two-entry queue between front and back end
// Holds finished sum records so that the front end keeps accumulating.
// ----------------------------------------------------------------------------
module csa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  csa_pkg::sums_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output logic           valid,
	output csa_pkg::sums_t rd_data
);

	csa_pkg::sums_t mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign full    = (fill_q == 2'd2);
	assign valid   = (fill_q != 2'd0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)      fill_q <= fill_q + 2'd1;
			else if (rd_en && !wr_en) fill_q <= fill_q - 2'd1;
		end
	end

endmodule

[rtl/core/csa_front.sv]
// ----------------------------------------------------------------------------
// csa_front: multiply-accumulate front end
// Squares and cross product in one stage, running sums in the next.
// ----------------------------------------------------------------------------
module csa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [csa_pkg::IN_W-1:0]    a_intensity,
	input  logic [csa_pkg::IN_W-1:0]    b_intensity,
	input  logic                        last,
	input  logic                        fifo_full,
	output logic                        fifo_wr,
	output csa_pkg::sums_t              fifo_data
);

	logic                        valid_s1;
	logic                        last_s1;
	logic [csa_pkg::PRD_W-1:0]   ab_s1;
	logic [csa_pkg::PRD_W-1:0]   aa_s1;
	logic [csa_pkg::PRD_W-1:0]   bb_s1;
	logic [csa_pkg::SUM_W-1:0]   cross_q;
	logic [csa_pkg::SUM_W-1:0]   first_q;
	logic [csa_pkg::SUM_W-1:0]   second_q;
	logic [csa_pkg::CNT_W-1:0]   cnt_q;
	logic                        stall;
	logic                        adv;
	logic                        room;
	csa_pkg::sums_t              nxt;

	// a finishing pair waits while the queue is full
	assign stall = valid_s1 && last_s1 && fifo_full;
	assign full  = stall;
	assign adv   = valid_s1 && !stall;
	assign room  = (cnt_q < csa_pkg::MAX_PAIRS);

	always_comb begin
		nxt.cross_sum = cross_q;
		nxt.first_sq  = first_q;
		nxt.second_sq = second_q;
		nxt.count     = cnt_q;
		if (room) begin
			nxt.cross_sum = cross_q  + csa_pkg::SUM_W'(ab_s1);
			nxt.first_sq  = first_q  + csa_pkg::SUM_W'(aa_s1);
			nxt.second_sq = second_q + csa_pkg::SUM_W'(bb_s1);
			nxt.count     = cnt_q + 1'b1;
		end
	end

	assign fifo_wr   = adv && last_s1;
	assign fifo_data = nxt;

	always_ff @(posedge clk) begin
		if (!stall) begin
			ab_s1   <= a_intensity * b_intensity;
			aa_s1   <= a_intensity * a_intensity;
			bb_s1   <= b_intensity * b_intensity;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cross_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (!stall) valid_s1 <= push;
			if (adv) begin
				if (last_s1) begin
					cross_q  <= '0;
					first_q  <= '0;
					second_q <= '0;
					cnt_q    <= '0;
				end else begin
					cross_q  <= nxt.cross_sum;
					first_q  <= nxt.first_sq;
					second_q <= nxt.second_sq;
					cnt_q    <= nxt.count;
				end
			end
		end
	end

endmodule

[rtl/core/csa_back.sv]
// ----------------------------------------------------------------------------
// csa_back: normalisation back end
// Forms A*B and S*S with one 32x32 multiplier, then finds q bit by bit.
// ----------------------------------------------------------------------------
module csa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fifo_valid,
	input  csa_pkg::sums_t              fifo_data,
	output logic                        fifo_rd,
	output logic                        empty,
	input  logic                        pop,
	output logic [csa_pkg::SIM_W-1:0]   similarity,
	output logic                        zero_norm,
	output logic [csa_pkg::CNT_W-1:0]   pair_count
);

	localparam int W    = 164;
	localparam int AW   = 2 * csa_pkg::SUM_W;
	localparam int HW   = csa_pkg::SUM_W / 2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_P, ST_MUL_R, ST_ADD, ST_CMP, ST_DONE
	} state_t;

	state_t                       state_q;
	logic [csa_pkg::SUM_W-1:0]    s_q, a_q, b_q;
	logic [csa_pkg::CNT_W-1:0]    cnt_q;
	logic [2:0]                   mcnt_q;
	logic [AW-1:0]                pp_q;
	logic [1:0]                   sh_q;
	logic [AW-1:0]                acc_q;
	logic [AW-1:0]                p_q;
	logic [W-1:0]                 r_q, m_q, n2_q, p2_q, t_q;
	logic [3:0]                   k_q;
	logic [csa_pkg::SIM_W-1:0]    q_q;
	logic                         out_valid_q;

	logic [csa_pkg::SUM_W-1:0]    mx, my;
	logic [HW-1:0]                xh, yh;
	logic [AW-1:0]                pp_sh, acc_sum;
	logic [W-1:0]                 n2_acc;
	logic                         zero_in;

	assign empty   = !out_valid_q;
	assign fifo_rd = (state_q == ST_IDLE) && fifo_valid && !out_valid_q;
	assign zero_in = (fifo_data.first_sq == '0) || (fifo_data.second_sq == '0);

	assign mx = (state_q == ST_MUL_P) ? a_q : s_q;
	assign my = (state_q == ST_MUL_P) ? b_q : s_q;
	assign xh = mcnt_q[1] ? mx[csa_pkg::SUM_W-1:HW] : mx[HW-1:0];
	assign yh = mcnt_q[0] ? my[csa_pkg::SUM_W-1:HW] : my[HW-1:0];

	always_comb begin
		case (sh_q)
			2'd0:    pp_sh = pp_q;
			2'd1:    pp_sh = pp_q << HW;
			2'd2:    pp_sh = pp_q << (2 * HW);
			default: pp_sh = '0;
		endcase
	end

	assign acc_sum = (mcnt_q == 3'd0) ? '0 : acc_q + pp_sh;
	assign n2_acc  = (t_q <= r_q) ? (n2_q + (p2_q << 1)) : n2_q;

	always_ff @(posedge clk) begin
		pp_q  <= AW'(64'(xh) * 64'(yh));
		sh_q  <= 2'(mcnt_q[1]) + 2'(mcnt_q[0]);
		acc_q <= acc_sum;
		t_q   <= m_q + n2_q + p2_q;
		if (fifo_rd) begin
			s_q   <= fifo_data.cross_sum;
			a_q   <= fifo_data.first_sq;
			b_q   <= fifo_data.second_sq;
			cnt_q <= fifo_data.count;
		end
		if (state_q == ST_MUL_P && mcnt_q == 3'd4) p_q <= acc_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mcnt_q      <= '0;
			m_q         <= '0;
			n2_q        <= '0;
			p2_q        <= '0;
			r_q         <= '0;
			k_q         <= '0;
			q_q         <= '0;
			out_valid_q <= 1'b0;
			similarity  <= '0;
			zero_norm   <= 1'b0;
			pair_count  <= '0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					mcnt_q <= '0;
					if (fifo_rd) begin
						if (zero_in) begin
							// either norm zero: report straight away
							similarity  <= '0;
							zero_norm   <= 1'b1;
							pair_count  <= fifo_data.count;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_MUL_P;
						end
					end
				end
				ST_MUL_P, ST_MUL_R: begin
					if (mcnt_q == 3'd4) begin
						mcnt_q <= '0;
						if (state_q == ST_MUL_P) begin
							state_q <= ST_MUL_R;
						end else begin
							r_q     <= W'(acc_sum) << 30;
							p2_q    <= W'(p_q) << 30;
							m_q     <= '0;
							n2_q    <= '0;
							q_q     <= '0;
							k_q     <= 4'd15;
							state_q <= ST_ADD;
						end
					end else begin
						mcnt_q <= mcnt_q + 3'd1;
					end
				end
				ST_ADD: state_q <= ST_CMP;
				ST_CMP: begin
					if (t_q <= r_q) begin
						m_q      <= t_q;
						q_q[k_q] <= 1'b1;
					end
					n2_q <= n2_acc >> 1;
					p2_q <= p2_q >> 2;
					if (k_q == 4'd0) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q - 4'd1;
						state_q <= ST_ADD;
					end
				end
				ST_DONE: begin
					similarity  <= (q_q > csa_pkg::SIM_ONE) ? csa_pkg::SIM_ONE : q_q;
					zero_norm   <= 1'b0;
					pair_count  <= cnt_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/cosine_similarity_accumulator_core.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_accumulator_core: streaming cosine similarity
// Accumulates intensity pairs and reports a.b / (|a||b|) in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
// Input channel: drive a_intensity, b_intensity and last with push; a
//   transaction completes on a clock edge with push high and full low.
//   Pairs are taken one per cycle; full rises only when a last pair meets
//   a full two-entry queue of finished vector pairs.
// Result channel: while empty is low, similarity, zero_norm and pair_count
//   show the oldest result; pop high with empty low completes it.
// Path: with the back end idle, a last pair passes one front-end stage, the
//   queue, the shared 32x32 multiplier for A*B and S*S, the bit-by-bit
//   search for q and the result register.
// Throughput: one pair a cycle while full is low; the back end takes the next vector
//   only when idle and empty, so shorter vectors stall the input via the queue.
// Pairs beyond 4096 in one vector are dropped but last still ends it.
// Reset clears sums, queue and result register; empty reads high.
// A stalled receiver holds the result; the back end waits, then the queue
//   fills, then full rises.
module cosine_similarity_accumulator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [csa_pkg::IN_W-1:0]    a_intensity,
	input  logic [csa_pkg::IN_W-1:0]    b_intensity,
	input  logic                        last,
	output logic                        empty,
	input  logic                        pop,
	output logic [csa_pkg::SIM_W-1:0]   similarity,
	output logic                        zero_norm,
	output logic [csa_pkg::CNT_W-1:0]   pair_count
);

	logic           fifo_wr;
	logic           fifo_full;
	logic           fifo_rd;
	logic           fifo_valid;
	csa_pkg::sums_t fifo_wdata;
	csa_pkg::sums_t fifo_rdata;

	// front end: multiply every accepted pair and accumulate up to the pair limit
	csa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.a_intensity (a_intensity),
		.b_intensity (b_intensity),
		.last        (last),
		.fifo_full   (fifo_full),
		.fifo_wr     (fifo_wr),
		.fifo_data   (fifo_wdata)
	);

	// hold finished sums until the back end is free
	csa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fifo_wr),
		.wr_data (fifo_wdata),
		.full    (fifo_full),
		.rd_en   (fifo_rd),
		.valid   (fifo_valid),
		.rd_data (fifo_rdata)
	);

	// back end: normalise and present the result
	csa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_data  (fifo_rdata),
		.fifo_rd    (fifo_rd),
		.empty      (empty),
		.pop        (pop),
		.similarity (similarity),
		.zero_norm  (zero_norm),
		.pair_count (pair_count)
	);

endmodule

[rtl/core/csa_checker.sv]
// ----------------------------------------------------------------------------
// csa_checker: port-level checks of the cosine similarity core
// Watches the result channel and the values it carries.
// ----------------------------------------------------------------------------
module csa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [csa_pkg::SIM_W-1:0]   similarity,
	input logic                        zero_norm,
	input logic [csa_pkg::CNT_W-1:0]   pair_count
);

	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && zero_norm) |-> (similarity == '0))
		else $error("zero norm with nonzero similarity");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (similarity <= csa_pkg::SIM_ONE))
		else $error("similarity above one");

	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pair_count != '0))
		else $error("result with no pairs");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(similarity) && $stable(pair_count)))
		else $error("result changed while stalled");

endmodule

bind cosine_similarity_accumulator_core csa_checker u_csa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.similarity (similarity),
	.zero_norm  (zero_norm),
	.pair_count (pair_count)
);
